// ----- sv/csrspmv_pkg.sv -----
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared types and constants of the sparse matrix-vector multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package csrspmv_pkg;

   localparam int COL_W     = 12;
   localparam int VAL_W     = 32;
   localparam int GAIN_W    = 16;
   localparam int ROW_W     = 16;
   localparam int ACC_W     = 64;
   // row sum rounded to Q16.16 needs one bit over 48 for the round-up of the max
   localparam int RND_W     = 49;
   localparam int APROD_W   = GAIN_W + RND_W;
   localparam int SUM_W     = APROD_W + 1;
   localparam int CSR_IDX_W = 1;

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = 2;
   localparam int Q_CNT_W   = 3;

   localparam logic signed [VAL_W-1:0] Y_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] Y_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_NONZERO = 2'd1,
      ACT_END_ROW = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic {
      OP_NONZERO = 1'b0,
      OP_END_ROW = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA = 1'b0,
      CSR_BETA  = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                   op;
      logic                     x_valid;
      logic signed [VAL_W-1:0]  value;
      logic signed [VAL_W-1:0]  x_value;
      logic signed [VAL_W-1:0]  y_old;
   } op_entry_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] alpha;
      logic signed [GAIN_W-1:0] beta;
   } gains_type;

endpackage

`default_nettype wire

// ----- sv/csrspmv_front.sv -----
// ----------------------------------------------------------------------------
// csrspmv_front
// Takes items, keeps the x vector store, fetches x for nonzeros and hands
// nonzero and end-of-row operations to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_front #(
   parameter int X_DEPTH = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic                                   busy,
   input  wire logic [1:0]                             req_action,
   input  wire logic [csrspmv_pkg::COL_W-1:0]          req_column_index,
   input  wire logic signed [csrspmv_pkg::VAL_W-1:0]   req_entry_value,
   input  wire logic signed [csrspmv_pkg::VAL_W-1:0]   req_y_old,
   output logic                                        push,
   output csrspmv_pkg::op_entry_type                   push_entry
);

   localparam int XAW = $clog2(X_DEPTH);
   localparam logic [31:0] X_LIMIT = 32'(X_DEPTH);

   logic [csrspmv_pkg::VAL_W-1:0] x_mem [X_DEPTH];

   csrspmv_pkg::action_type act;
   logic                    accept;
   logic                    in_range;
   logic [XAW+csrspmv_pkg::COL_W-1:0] col_wide;
   logic [XAW-1:0]          addr;

   logic                    valid_ff, valid_in;
   csrspmv_pkg::op_type     op_ff, op_in;
   logic                    in_range_ff;
   logic signed [csrspmv_pkg::VAL_W-1:0] value_ff;
   logic signed [csrspmv_pkg::VAL_W-1:0] y_old_ff;
   logic signed [csrspmv_pkg::VAL_W-1:0] x_rd_ff;

   assign act      = csrspmv_pkg::action_type'(req_action);
   assign accept   = start && !busy;
   assign in_range = 32'(req_column_index) < X_LIMIT;
   assign col_wide = {{XAW{1'b0}}, req_column_index};
   assign addr     = col_wide[XAW-1:0];

   always_comb begin
      valid_in = 1'b0;
      op_in    = csrspmv_pkg::OP_NONZERO;
      case (act)
         csrspmv_pkg::ACT_NONZERO: begin
            valid_in = accept;
         end
         csrspmv_pkg::ACT_END_ROW: begin
            valid_in = accept;
            op_in    = csrspmv_pkg::OP_END_ROW;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   // x store: write on load, registered read for nonzeros
   always_ff @(posedge clock) begin
      if (accept && act == csrspmv_pkg::ACT_LOAD && in_range) begin
         x_mem[addr] <= req_entry_value;
      end
      if (accept) begin
         x_rd_ff <= x_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_in;
         in_range_ff <= in_range;
         value_ff    <= req_entry_value;
         y_old_ff    <= req_y_old;
      end
   end

   assign push               = valid_ff;
   assign push_entry.op      = op_ff;
   assign push_entry.x_valid = in_range_ff;
   assign push_entry.value   = value_ff;
   assign push_entry.x_value = x_rd_ff;
   assign push_entry.y_old   = y_old_ff;

endmodule

`default_nettype wire

// ----- sv/csrspmv_queue.sv -----
// ----------------------------------------------------------------------------
// csrspmv_queue
// Short FIFO of operations between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire csrspmv_pkg::op_entry_type   push_entry,
   input  wire logic                        pop,
   output csrspmv_pkg::op_entry_type        head,
   output logic                             not_empty,
   output logic                             level_high
);

   csrspmv_pkg::op_entry_type entries_ff [csrspmv_pkg::Q_DEPTH];

   logic [csrspmv_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [csrspmv_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [csrspmv_pkg::Q_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign not_empty  = count_ff != '0;
   // one slot kept for the item sitting in the front register
   assign level_high = count_ff >= csrspmv_pkg::Q_CNT_W'(csrspmv_pkg::Q_DEPTH - 1);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != csrspmv_pkg::Q_CNT_W'(csrspmv_pkg::Q_DEPTH) || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ----- sv/csrspmv_back.sv -----
// ----------------------------------------------------------------------------
// csrspmv_back
// Arithmetic back end: multiply, saturating row accumulation, and the
// alpha/beta combine with output saturation. Four stages, one op per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   not_empty,
   input  wire csrspmv_pkg::op_entry_type              head,
   input  wire csrspmv_pkg::gains_type                 gains,
   output logic                                        pop,
   output logic                                        rsp_strobe,
   output logic [csrspmv_pkg::ROW_W-1:0]               rsp_row_number,
   output logic signed [csrspmv_pkg::VAL_W-1:0]        rsp_y_new,
   output logic                                        rsp_saturated
);

   localparam int ACC_W   = csrspmv_pkg::ACC_W;
   localparam int RND_W   = csrspmv_pkg::RND_W;
   localparam int APROD_W = csrspmv_pkg::APROD_W;
   localparam int SUM_W   = csrspmv_pkg::SUM_W;
   localparam int ROW_W   = csrspmv_pkg::ROW_W;
   localparam int VAL_W   = csrspmv_pkg::VAL_W;

   // stage 1: products
   logic                     v1_ff;
   csrspmv_pkg::op_type      op1_ff;
   logic signed [ACC_W-1:0]  prod1_ff, prod1_in;
   logic signed [ACC_W-1:0]  prod_nz;
   logic signed [ACC_W-1:0]  prod_b;

   // stage 2: accumulator and row state
   logic signed [ACC_W-1:0]  row_sum_ff, row_sum_in;
   logic                     clipped_ff, clipped_in;
   logic [ROW_W-1:0]         row_ctr_ff, row_ctr_in;
   logic signed [ACC_W:0]    sum_w;
   logic                     acc_ovf;
   logic signed [RND_W-1:0]  rounded;
   logic                     v2_ff;
   logic signed [RND_W-1:0]  rnd2_ff;
   logic signed [ACC_W-1:0]  bprod2_ff;
   logic                     clip2_ff;
   logic [ROW_W-1:0]         row2_ff;

   // stage 3: alpha product
   logic                       v3_ff;
   logic signed [APROD_W-1:0]  aprod3_ff;
   logic signed [ACC_W-1:0]    bprod3_ff;
   logic                       clip3_ff;
   logic [ROW_W-1:0]           row3_ff;

   // stage 4: combine and clip
   logic signed [SUM_W-1:0]  total;
   logic                     over_hi;
   logic                     over_lo;
   logic                     end_row1;

   assign pop      = not_empty;
   assign end_row1 = v1_ff && op1_ff == csrspmv_pkg::OP_END_ROW;

   assign prod_nz = $signed(head.value) * $signed(head.x_value);
   assign prod_b  = $signed(gains.beta) * $signed(head.y_old);

   always_comb begin
      prod1_in = '0;
      case (head.op)
         csrspmv_pkg::OP_END_ROW: prod1_in = prod_b;
         csrspmv_pkg::OP_NONZERO: prod1_in = head.x_valid ? prod_nz : '0;
         default:                 prod1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op1_ff   <= head.op;
         prod1_ff <= prod1_in;
      end
   end

   // saturating add into the row sum
   assign sum_w   = {prod1_ff[ACC_W-1], prod1_ff} + {row_sum_ff[ACC_W-1], row_sum_ff};
   assign acc_ovf = sum_w[ACC_W] != sum_w[ACC_W-1];
   // round half up to Q16.16
   assign rounded = {row_sum_ff[ACC_W-1], row_sum_ff[ACC_W-1:16]}
                  + RND_W'(row_sum_ff[15]);

   always_comb begin
      row_sum_in = row_sum_ff;
      clipped_in = clipped_ff;
      row_ctr_in = row_ctr_ff;
      if (v1_ff) begin
         case (op1_ff)
            csrspmv_pkg::OP_NONZERO: begin
               if (acc_ovf) begin
                  row_sum_in = sum_w[ACC_W] ? csrspmv_pkg::ACC_MIN : csrspmv_pkg::ACC_MAX;
                  clipped_in = 1'b1;
               end else begin
                  row_sum_in = sum_w[ACC_W-1:0];
               end
            end
            csrspmv_pkg::OP_END_ROW: begin
               row_sum_in = '0;
               clipped_in = 1'b0;
               row_ctr_in = row_ctr_ff + 1'b1;
            end
            default: begin
               row_sum_in = row_sum_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         rsp_strobe <= 1'b0;
         row_sum_ff <= '0;
         clipped_ff <= 1'b0;
         row_ctr_ff <= '0;
      end else begin
         v1_ff      <= pop;
         v2_ff      <= end_row1;
         v3_ff      <= v2_ff;
         rsp_strobe <= v3_ff;
         row_sum_ff <= row_sum_in;
         clipped_ff <= clipped_in;
         row_ctr_ff <= row_ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_row1) begin
         rnd2_ff   <= rounded;
         bprod2_ff <= prod1_ff;
         clip2_ff  <= clipped_ff;
         row2_ff   <= row_ctr_ff;
      end
      if (v2_ff) begin
         aprod3_ff <= $signed(gains.alpha) * rnd2_ff;
         bprod3_ff <= bprod2_ff;
         clip3_ff  <= clip2_ff;
         row3_ff   <= row2_ff;
      end
      if (v3_ff) begin
         rsp_row_number <= row3_ff;
         rsp_saturated  <= clip3_ff || over_hi || over_lo;
         if (over_hi) begin
            rsp_y_new <= csrspmv_pkg::Y_MAX;
         end else if (over_lo) begin
            rsp_y_new <= csrspmv_pkg::Y_MIN;
         end else begin
            rsp_y_new <= total[VAL_W-1:0];
         end
      end
   end

   assign total   = SUM_W'(aprod3_ff) + SUM_W'(bprod3_ff);
   assign over_hi = total > SUM_W'(csrspmv_pkg::Y_MAX);
   assign over_lo = total < SUM_W'(csrspmv_pkg::Y_MIN);

`ifndef SYNTHESIS
   a_row_clears: assert property (@(posedge clock) disable iff (reset)
      end_row1 |=> (row_sum_ff == '0 && !clipped_ff))
      else $error("row sum not cleared after end of row");

   a_row_count: assert property (@(posedge clock) disable iff (reset)
      end_row1 |=> row_ctr_ff == ROW_W'($past(row_ctr_ff) + 1'b1))
      else $error("row counter did not advance by one");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      v3_ff |=> rsp_strobe)
      else $error("finished row produced no result");
`endif

endmodule

`default_nettype wire

// ----- sv/csr_sparse_matrix_vector_multiply_top.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_top
// y = alpha*A*x + beta*y over a compressed-row matrix stream, Q16.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req_* when start is high and busy is low. A load item
//   writes x[column_index]; a nonzero item adds entry_value*x[column_index]
//   to the row sum; an end-of-row item produces one result on rsp_* and
//   clears the row sum. Loads and the none action code produce nothing.
//   rsp_strobe is high for one cycle per result; the receiver cannot stall.
//   alpha_gain (index 0) and beta_gain (index 1) are written through csr_*;
//   the user must write them only while no item is in flight; the block does not enforce it.
// Timing:
//   One item per cycle sustained. A result shows on rsp_* once its end-of-row
//   item has passed the front register with x-store read, the queue, the
//   product stage, the accumulate stage, the alpha multiply and the output
//   clip register. busy rises only if the queue fills, which the back end,
//   draining one op per cycle, does not allow in practice.
// Reset:
//   Synchronous; clears row sum, clip flag, row number and the queue, and
//   sets alpha_gain to 1 and beta_gain to 0. The x store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_top #(
   parameter int X_DEPTH = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [1:0]                             req_action,
   input  wire logic [csrspmv_pkg::COL_W-1:0]          req_column_index,
   input  wire logic signed [csrspmv_pkg::VAL_W-1:0]   req_entry_value,
   input  wire logic signed [csrspmv_pkg::VAL_W-1:0]   req_y_old,
   output logic                                        rsp_strobe,
   output logic [csrspmv_pkg::ROW_W-1:0]               rsp_row_number,
   output logic signed [csrspmv_pkg::VAL_W-1:0]        rsp_y_new,
   output logic                                        rsp_saturated,
   input  wire logic                                   csr_write_enable,
   input  wire logic [csrspmv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [csrspmv_pkg::GAIN_W-1:0]         csr_write_data
);

   csrspmv_pkg::gains_type     gains_ff, gains_in;
   csrspmv_pkg::csr_index_type csr_sel;

   logic                       push;
   csrspmv_pkg::op_entry_type  push_entry;
   csrspmv_pkg::op_entry_type  head;
   logic                       not_empty;
   logic                       level_high;
   logic                       pop;

   assign csr_sel = csrspmv_pkg::csr_index_type'(csr_index);

   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         case (csr_sel)
            csrspmv_pkg::CSR_ALPHA: gains_in.alpha = csr_write_data;
            csrspmv_pkg::CSR_BETA:  gains_in.beta  = csr_write_data;
            default:                gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.alpha <= csrspmv_pkg::GAIN_W'(1);
         gains_ff.beta  <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign busy = level_high;

   csrspmv_front #(
      .X_DEPTH (X_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_column_index (req_column_index),
      .req_entry_value  (req_entry_value),
      .req_y_old        (req_y_old),
      .push             (push),
      .push_entry       (push_entry)
   );

   csrspmv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .level_high (level_high)
   );

   csrspmv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .not_empty      (not_empty),
      .head           (head),
      .gains          (gains_ff),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_row_number (rsp_row_number),
      .rsp_y_new      (rsp_y_new),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

`default_nettype wire
